/* design/s2fr_pkg.sv */
package s2fr_pkg;

  localparam logic [7:0] START_BYTE = 8'd27;
  localparam logic [7:0] TOKEN_BYTE = 8'd14;

  // Parser phase, one-hot
  typedef enum logic [6:0] {
    PH_HUNT  = 7'b0000001,
    PH_SEQ   = 7'b0000010,
    PH_LENHI = 7'b0000100,
    PH_LENLO = 7'b0001000,
    PH_TOKEN = 7'b0010000,
    PH_BODY  = 7'b0100000,
    PH_CSUM  = 7'b1000000
  } s2fr_phase_e;

  typedef enum logic [2:0] {
    EV_IDLE  = 3'd0,
    EV_DATA  = 3'd1,
    EV_GOOD  = 3'd2,
    EV_BAD   = 3'd3,
    EV_TOKEN = 3'd4
  } s2fr_event_e;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [7:0]  frame_seq;
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
    s2fr_event_e event_kind;
  } s2fr_result_t;

endpackage

/* design/s2fr_parser.sv */
module s2fr_parser
  import s2fr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [7:0]   byte_i,
  output s2fr_result_t res_o
);

  s2fr_phase_e phase_q, phase_d;
  logic [7:0]  seq_q, seq_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  xor_x;
  logic [15:0] cnt_inc;

  always_comb begin
    xor_x   = xor_q ^ byte_i;
    cnt_inc = cnt_q + 16'd1;
    phase_d = phase_q;
    seq_d   = seq_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    xor_d   = xor_x;
    res_o.event_kind    = EV_IDLE;
    res_o.payload_byte  = 8'h00;
    res_o.payload_index = 16'h0000;
    case (phase_q)
      PH_SEQ: begin
        seq_d   = byte_i;
        phase_d = PH_LENHI;
      end
      PH_LENHI: begin
        len_d   = {byte_i, 8'h00};
        phase_d = PH_LENLO;
      end
      PH_LENLO: begin
        len_d   = {len_q[15:8], byte_i};
        phase_d = PH_TOKEN;
      end
      PH_TOKEN: begin
        if (byte_i == TOKEN_BYTE) begin
          cnt_d   = 16'h0000;
          phase_d = (len_q == 16'h0000) ? PH_CSUM : PH_BODY;
        end else begin
          res_o.event_kind = EV_TOKEN;
          phase_d          = PH_HUNT;
        end
      end
      PH_BODY: begin
        res_o.event_kind    = EV_DATA;
        res_o.payload_byte  = byte_i;
        res_o.payload_index = cnt_q;
        cnt_d               = cnt_inc;
        if (cnt_inc == len_q) begin
          phase_d = PH_CSUM;
        end
      end
      PH_CSUM: begin
        res_o.event_kind = (xor_x == 8'h00) ? EV_GOOD : EV_BAD;
        phase_d          = PH_HUNT;
      end
      default: begin
        // hunting: restart the running check at this byte
        xor_d   = byte_i;
        phase_d = (byte_i == START_BYTE) ? PH_SEQ : PH_HUNT;
      end
    endcase
    res_o.frame_seq    = seq_d;
    res_o.frame_length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      seq_q   <= 8'h00;
      len_q   <= 16'h0000;
      cnt_q   <= 16'h0000;
      xor_q   <= 8'h00;
    end else if (en_i) begin
      phase_q <= phase_d;
      seq_q   <= seq_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      xor_q   <= xor_d;
    end
  end

endmodule

/* design/stk500v2_frame_receiver.sv */
// Each accepted byte waits in the input register; its result beat is held in the result register.
// Throughput: one byte per cycle; the input register and the result register
// each advance whenever the stage after them is free, and s_axis_tready drops
// only while both stages hold a beat and m_axis_tready is low.
// Reset: rst_ni (asynchronous, active low) empties both stages and returns the
// parser to hunting for the start byte with sequence, length and check cleared.
module stk500v2_frame_receiver
  import s2fr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] payload_byte, [23:8] payload_index,
                                      // [31:24] frame_seq, [47:32] frame_length
  output logic [2:0]  m_axis_tuser    // [2:0] event_kind
);

  logic         in_vld_q, in_vld_d;
  logic [7:0]   in_byte_q;
  logic         out_vld_q, out_vld_d;
  s2fr_result_t out_res_q;
  s2fr_result_t res;
  logic         out_adv;
  logic         in_take;
  logic         parse_en;

  // The result register is free when empty or being drained this cycle.
  assign out_adv  = !out_vld_q || m_axis_tready;
  // Hand the held byte to the parser only when its result can be captured.
  assign parse_en = in_vld_q && out_adv;
  assign s_axis_tready = !in_vld_q || out_adv;
  assign in_take  = s_axis_tvalid && s_axis_tready;

  s2fr_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (parse_en),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (out_adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (out_adv) begin
      out_vld_d = in_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers: the input byte loads on the handshake, the result on parse_en; both hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
    end
    if (parse_en) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_res_q.event_kind;
  assign m_axis_tdata  = {out_res_q.frame_length, out_res_q.frame_seq,
                          out_res_q.payload_index, out_res_q.payload_byte};

`ifndef NO_ASSERTIONS
  // Non-payload beats carry zero data and index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != EV_DATA) |->
      (m_axis_tdata[23:0] == 24'h000000))
    else $error("payload fields nonzero on a non-payload beat");

  // Input back-pressure only while the result stage is full and stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back-pressure");

  // A byte taken into an empty pipeline passes through the input and result registers to the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !in_vld_q && !m_axis_tvalid) |=> ##1
      m_axis_tvalid)
    else $error("result beat missing two cycles after input beat");
`endif

endmodule
